[hdl/dmb5_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dmb5_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int BORDER     = 2;
	localparam int MIN_SIZE   = 5;

	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 13;
	localparam int ROW_W      = 12;
	localparam int COL_W      = 10;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;

	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;

	// one line memory entry per position of a (W+1)-pixel diagonal step
	localparam int MEM_DEPTH = MAX_WIDTH + 1;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int PIX_W     = 32;
	localparam int TAPS      = 2 * BORDER;
	localparam int ENTRY_W   = TAPS * PIX_W;

	localparam int SUM_W      = 11;
	localparam int RECIP      = 13108;
	localparam int RECIP_W    = 14;
	localparam int PROD_W     = SUM_W + RECIP_W;
	localparam int RECIP_SHIFT = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] pix_blue;
		logic [7:0] pix_green;
		logic [7:0] pix_red;
		logic [7:0] pix_alpha;
	} pix_t;

	typedef struct packed {
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
		logic [7:0]       out_blue;
		logic [7:0]       out_green;
		logic [7:0]       out_red;
		logic [7:0]       out_alpha;
		logic             frame_end;
	} res_t;

endpackage

`default_nettype wire

[hdl/diagonal_motion_blur_5tap_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Diagonal 5-tap box blur on a raster BGRA pixel stream.
// Input channel pix_valid/pix_ready/pix: one pixel per item, raster order.
// Output channel res_valid/res_ready/res: one result item per input item,
// tagged with row/column; the emitted position trails the input by 2W+2
// pixels, so the first 2W+2 items after a restart are the zero tail border
// of the previous frame. Border pixels (two on every side) come out zero.
// Path: an accepted item passes stage 1 (read), stage 2 (sums) and the
// output stage. Throughput: one item per clock while res_ready is high. The line
// memory (W+1 entries, 128 bits each) takes one read and one write per item;
// each entry holds the four older diagonal taps, so one read serves them all.
// Config: cfg_we/cfg_idx/cfg_data write frame_width (0) or frame_height (1),
// clamped to 5..max; any write to either restarts the stream counters.
// Reset: size goes to 640x480, counters restart, pipeline empties. The line
// memory is not cleared; it is always rewritten before a tap is used.
// Stall: if res_ready is low with a result waiting, the whole pipe holds and
// pix_ready drops in the same cycle; nothing is lost or repeated.

module diagonal_motion_blur_5tap_top
	import dmb5_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  pix_valid,
	output logic                       pix_ready,
	input  wire pix_t                  pix,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output res_t                       res
);

	// configuration and stream position
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [ADDR_W-1:0]   ptr_q;
	logic [ROW_W-1:0]    in_row_q, em_row_q;
	logic [COL_W-1:0]    in_col_q, em_col_q;

	logic [WIDTH_W-1:0]  cfg_w_nxt;
	logic [HEIGHT_W-1:0] cfg_h_nxt;
	logic                cfg_hit;

	logic adv, pix_acc;
	logic inner, last;
	logic in_col_end, in_row_end, em_col_end, em_row_end;

	// pipeline
	logic                valid_s1, valid_s2;
	logic [PIX_W-1:0]    pix_s1;
	logic [ENTRY_W-1:0]  rd_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic [ROW_W-1:0]    row_s1, row_s2;
	logic [COL_W-1:0]    col_s1, col_s2;
	logic                inner_s1, last_s1, last_s2;
	logic [SUM_W-1:0]    sum_s2 [4];
	logic [SUM_W-1:0]    sum_nxt [4];
	logic [PROD_W-1:0]   prod [4];
	logic [7:0]          quo [4];

	logic                res_valid_q;
	res_t                res_q;

	// line memory: entry holds {p(t-4L), p(t-3L), p(t-2L), p(t-L)}, L = W+1
	logic [ENTRY_W-1:0] line_mem [MEM_DEPTH];

	assign adv       = !res_valid_q || res_ready;
	assign pix_ready = adv;
	assign pix_acc   = pix_valid && adv;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// clamp on write
	always_comb begin
		cfg_w_nxt = width_q;
		cfg_h_nxt = height_q;
		cfg_hit   = 1'b0;
		if (cfg_we) begin
			case (cfg_idx)
				CFG_WIDTH: begin
					cfg_hit = 1'b1;
					if (cfg_data < CFG_DATA_W'(MIN_SIZE))
						cfg_w_nxt = WIDTH_W'(MIN_SIZE);
					else if (cfg_data > CFG_DATA_W'(MAX_WIDTH))
						cfg_w_nxt = WIDTH_W'(MAX_WIDTH);
					else
						cfg_w_nxt = cfg_data[WIDTH_W-1:0];
				end
				CFG_HEIGHT: begin
					cfg_hit = 1'b1;
					if (cfg_data < CFG_DATA_W'(MIN_SIZE))
						cfg_h_nxt = HEIGHT_W'(MIN_SIZE);
					else if (cfg_data > CFG_DATA_W'(MAX_HEIGHT))
						cfg_h_nxt = HEIGHT_W'(MAX_HEIGHT);
					else
						cfg_h_nxt = cfg_data;
				end
				default: cfg_hit = 1'b0;
			endcase
		end
	end

	always_comb begin
		in_col_end = WIDTH_W'(in_col_q) == width_q - WIDTH_W'(1);
		in_row_end = HEIGHT_W'(in_row_q) == height_q - HEIGHT_W'(1);
		em_col_end = WIDTH_W'(em_col_q) == width_q - WIDTH_W'(1);
		em_row_end = HEIGHT_W'(em_row_q) == height_q - HEIGHT_W'(1);
		last       = in_col_end && in_row_end;
		inner      = (em_row_q >= ROW_W'(BORDER)) && (em_col_q >= COL_W'(BORDER)) &&
		             (HEIGHT_W'(em_row_q) + HEIGHT_W'(BORDER) < height_q) &&
		             (WIDTH_W'(em_col_q) + WIDTH_W'(BORDER) < width_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_W'(WIDTH_RESET);
			height_q <= HEIGHT_W'(HEIGHT_RESET);
			ptr_q    <= '0;
			in_row_q <= '0;
			in_col_q <= '0;
			em_row_q <= ROW_W'(HEIGHT_RESET - 3);
			em_col_q <= COL_W'(WIDTH_RESET - 2);
		end else if (cfg_hit) begin
			width_q  <= cfg_w_nxt;
			height_q <= cfg_h_nxt;
			ptr_q    <= '0;
			in_row_q <= '0;
			in_col_q <= '0;
			em_row_q <= ROW_W'(cfg_h_nxt - HEIGHT_W'(3));
			em_col_q <= COL_W'(cfg_w_nxt - WIDTH_W'(2));
		end else if (pix_acc) begin
			ptr_q <= (WIDTH_W'(ptr_q) == width_q) ? '0 : ptr_q + ADDR_W'(1);
			if (in_col_end) begin
				in_col_q <= '0;
				in_row_q <= in_row_end ? '0 : in_row_q + ROW_W'(1);
			end else begin
				in_col_q <= in_col_q + COL_W'(1);
			end
			if (em_col_end) begin
				em_col_q <= '0;
				em_row_q <= em_row_end ? '0 : em_row_q + ROW_W'(1);
			end else begin
				em_col_q <= em_col_q + COL_W'(1);
			end
		end
	end

	// read on accept, write back from stage 1 at the same slot; the next
	// read is always a different slot since L >= 6
	always_ff @(posedge clk) begin
		if (pix_acc)
			rd_s1 <= line_mem[ptr_q];
		if (adv && valid_s1)
			line_mem[addr_s1] <= {rd_s1[ENTRY_W-PIX_W-1:0], pix_s1};
	end

	// stage 1: item captured alongside the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv)
			valid_s1 <= pix_acc;
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			pix_s1   <= {pix.pix_alpha, pix.pix_red, pix.pix_green, pix.pix_blue};
			addr_s1  <= ptr_q;
			row_s1   <= em_row_q;
			col_s1   <= em_col_q;
			inner_s1 <= inner;
			last_s1  <= last;
		end
	end

	// stage 2: five-tap sums per channel, border forced to zero
	always_comb begin
		for (int ch = 0; ch < 4; ch++) begin
			sum_nxt[ch] = SUM_W'(pix_s1[8*ch +: 8]);
			for (int k = 0; k < TAPS; k++)
				sum_nxt[ch] = sum_nxt[ch] + SUM_W'(rd_s1[PIX_W*k + 8*ch +: 8]);
			if (!inner_s1)
				sum_nxt[ch] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			for (int ch = 0; ch < 4; ch++)
				sum_s2[ch] <= sum_nxt[ch];
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			last_s2 <= last_s1;
		end
	end

	// output stage: divide by five as multiply by reciprocal (exact for sums < 1280)
	always_comb begin
		for (int ch = 0; ch < 4; ch++) begin
			prod[ch] = PROD_W'(sum_s2[ch]) * PROD_W'(RECIP);
			quo[ch]  = prod[ch][RECIP_SHIFT +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (adv)
			res_valid_q <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			res_q.out_row   <= row_s2;
			res_q.out_col   <= col_s2;
			res_q.out_blue  <= quo[0];
			res_q.out_green <= quo[1];
			res_q.out_red   <= quo[2];
			res_q.out_alpha <= quo[3];
			res_q.frame_end <= last_s2;
		end
	end

	// line pointer never leaves the W+1 slots in use
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		WIDTH_W'(ptr_q) <= width_q)
		else $error("line pointer beyond active line length");

	// both column counters stay inside the active row
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(WIDTH_W'(in_col_q) < width_q) && (WIDTH_W'(em_col_q) < width_q))
		else $error("column counter beyond frame width");

	// top and left border results carry zero channels
	a_border_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_q.out_row < ROW_W'(BORDER) || res_q.out_col < COL_W'(BORDER)))
		|-> (res_q.out_blue == 8'd0 && res_q.out_green == 8'd0 &&
		     res_q.out_red == 8'd0 && res_q.out_alpha == 8'd0))
		else $error("non-zero result on border");

endmodule

`default_nettype wire

[dv/diagonal_motion_blur_5tap_top_test.sv]
`timescale 1ns / 1ps

module diagonal_motion_blur_5tap_top_test;
	import dmb5_pkg::*;

	// Register indexes beyond the list: writes there must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	// Pixel history deep enough for four diagonal steps at the widest row.
	localparam int HIST_DEPTH = 4 * MAX_WIDTH + 4;

	// Number of random items before the random phase stops.
	localparam int RANDOM_ITEMS = 500;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic pix_valid;
	logic pix_ready;
	pix_t pix;
	logic res_valid;
	logic res_ready;
	res_t res;

	// Idling switches for each side.
	bit sender_gaps;
	bit receiver_stalls;

	int errors;

	// Blur predictor state: pixel history, stream positions and frame size.
	pix_t pixel_history [HIST_DEPTH];
	int hist_slot;
	int in_row;
	int in_col;
	int emit_row;
	int emit_col;
	int width_now;
	int height_now;

	// Blurred pixels predicted but not yet seen on the result channel.
	res_t pending_results [$];

	diagonal_motion_blur_5tap_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic int clamp_size(int v, int hi);
		if (v < MIN_SIZE)
			return MIN_SIZE;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Any size write restarts the stream. History contents are kept; the
	// emit position lags far enough that stale entries are never tapped.
	task automatic restart_stream();
		hist_slot = 0;
		in_row    = 0;
		in_col    = 0;
		emit_row  = height_now - 3;
		emit_col  = width_now - 2;
	endtask

	task automatic step_position(inout int row, inout int col);
		col++;
		if (col >= width_now) begin
			col = 0;
			row++;
			if (row >= height_now)
				row = 0;
		end
	endtask

	// One pixel in, one blurred pixel out. The four older diagonal taps sit
	// k*(W+1) items back; they are read before the new pixel is stored.
	task automatic blur_step(input pix_t p, output res_t r);
		int sum_b;
		int sum_g;
		int sum_r;
		int sum_a;
		int slot;
		pix_t tap;
		r = '0;
		r.out_row = emit_row[ROW_W-1:0];
		r.out_col = emit_col[COL_W-1:0];
		if (emit_row >= BORDER && emit_col >= BORDER &&
				emit_row + BORDER < height_now && emit_col + BORDER < width_now) begin
			sum_b = int'(p.pix_blue);
			sum_g = int'(p.pix_green);
			sum_r = int'(p.pix_red);
			sum_a = int'(p.pix_alpha);
			for (int k = 1; k <= TAPS; k++) begin
				slot = (hist_slot + HIST_DEPTH - (k * (width_now + 1)) % HIST_DEPTH)
					% HIST_DEPTH;
				tap = pixel_history[slot];
				sum_b += int'(tap.pix_blue);
				sum_g += int'(tap.pix_green);
				sum_r += int'(tap.pix_red);
				sum_a += int'(tap.pix_alpha);
			end
			r.out_blue  = 8'(sum_b / 5);
			r.out_green = 8'(sum_g / 5);
			r.out_red   = 8'(sum_r / 5);
			r.out_alpha = 8'(sum_a / 5);
		end
		r.frame_end = (in_row + 1 == height_now) && (in_col + 1 == width_now);
		pixel_history[hist_slot] = p;
		hist_slot = (hist_slot + 1) % HIST_DEPTH;
		step_position(in_row, in_col);
		step_position(emit_row, emit_col);
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Sampled at the rising edge, before any nonblocking update lands, so
	// both channels and the register port are seen as the block saw them.
	// A result is retired before the input of the same edge is predicted;
	// since the pipe registers every item, the two can never be the same item.
	always @(posedge clk) begin : watch_ports
		res_t want;
		res_t predicted;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result item with none expected, actual row %0d col %0d",
						$time, res.out_row, res.out_col);
					errors++;
				end else begin
					want = pending_results.pop_front();
					check_field("out_row",   32'(want.out_row),   32'(res.out_row));
					check_field("out_col",   32'(want.out_col),   32'(res.out_col));
					check_field("out_blue",  32'(want.out_blue),  32'(res.out_blue));
					check_field("out_green", 32'(want.out_green), 32'(res.out_green));
					check_field("out_red",   32'(want.out_red),   32'(res.out_red));
					check_field("out_alpha", 32'(want.out_alpha), 32'(res.out_alpha));
					check_field("frame_end", 32'(want.frame_end), 32'(res.frame_end));
				end
			end
			if (cfg_we) begin
				if (cfg_idx == CFG_WIDTH) begin
					width_now = clamp_size(int'(cfg_data), MAX_WIDTH);
					restart_stream();
				end else if (cfg_idx == CFG_HEIGHT) begin
					height_now = clamp_size(int'(cfg_data), MAX_HEIGHT);
					restart_stream();
				end
			end
			if (pix_valid && pix_ready) begin
				blur_step(pix, predicted);
				pending_results.push_back(predicted);
			end
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Result side: random stall bursts while enabled.
	initial begin
		res_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (receiver_stalls && $urandom_range(0, 5) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				res_ready <= 1'b1;
			end
		end
	end

	function automatic logic [7:0] random_channel();
		case ($urandom_range(0, 9))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic pix_t make_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r,
			logic [7:0] a);
		pix_t p;
		p.pix_blue  = b;
		p.pix_green = g;
		p.pix_red   = r;
		p.pix_alpha = a;
		return p;
	endfunction

	function automatic pix_t random_pixel();
		return make_pixel(random_channel(), random_channel(), random_channel(),
			random_channel());
	endfunction

	// Offer one item and hold it until taken. Valid is left high on return
	// so back-to-back items need no toggle; a gap, if any, lowers it first.
	task automatic send_pixel(input pix_t p);
		if (sender_gaps && $urandom_range(0, 5) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix       <= p;
		@(posedge clk);
		while (!pix_ready)
			@(posedge clk);
	endtask

	task automatic send_random(input int count);
		repeat (count)
			send_pixel(random_pixel());
	endtask

	// Stop offering items and wait until every predicted result is back,
	// then idle on to cover the pipe depth.
	task automatic wait_idle();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register write: one edge with the enable high. Starts on a fresh edge
	// so a following write never re-drives cfg_we in the same step.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	task automatic set_size(input int w, input int h);
		wait_idle();
		write_reg(CFG_WIDTH, CFG_DATA_W'(w));
		write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Out of reset at 640x480: the first items are the tail border of a
	// previous frame, starting at row 477, column 638.
	task automatic test_reset_size();
		sender_gaps     = 1'b1;
		receiver_stalls = 1'b1;
		send_random(30);
		wait_idle();
	endtask

	// Smallest frame, sizes written below the floor. One full 5x5 frame:
	// the single interior pixel sums five 255s in blue, zeros in green,
	// uneven reds for the floor, and the last item flags the frame end.
	task automatic test_smallest_frame();
		wait_idle();
		write_reg(CFG_WIDTH, '0);
		write_reg(CFG_HEIGHT, CFG_DATA_W'(4));
		for (int k = 0; k < 25; k++)
			send_pixel(make_pixel(8'hFF, 8'h00, 8'(k * 10 + 3), (k % 2) ? 8'hAA : 8'h55));
		wait_idle();
	endtask

	// Writes above the ceiling and just past it clamp to the maximum, writes below the floor
	// to the minimum; a write to an index past the list changes nothing and does not restart.
	task automatic test_register_limits();
		wait_idle();
		write_reg(CFG_WIDTH, '1);
		write_reg(CFG_HEIGHT, '1);
		send_random(20);
		wait_idle();
		write_reg(CFG_WIDTH, CFG_DATA_W'(4));
		send_random(40);
		wait_idle();
		write_reg(CFG_WIDTH, CFG_DATA_W'(MAX_WIDTH + 1));
		write_reg(CFG_HEIGHT, CFG_DATA_W'(MAX_HEIGHT + 1));
		send_random(20);
		wait_idle();
		write_reg(CFG_HEIGHT, CFG_DATA_W'(MIN_SIZE - 1));
		send_random(20);
		set_size(7, 6);
		send_random(30);
		wait_idle();
		write_reg(CFG_SPARE_2, '1);
		write_reg(CFG_SPARE_3, CFG_DATA_W'($urandom));
		send_random(50);
		wait_idle();
	endtask

	// Widest row: the line pointer covers only the start of the long line; the items
	// stay in the tail border and the row wrap of the emitted position.
	task automatic test_widest_rows();
		set_size(MAX_WIDTH, MIN_SIZE);
		send_random(300);
		wait_idle();
	endtask

	// Tallest frame: emitted rows start at the top of the row range and wrap.
	task automatic test_tallest_frame();
		set_size(MIN_SIZE, MAX_HEIGHT);
		send_random(300);
		wait_idle();
	endtask

	// Sender holds off mid-frame until the result side has fully caught up.
	task automatic test_pause_mid_frame();
		set_size(9, 7);
		send_random(40);
		wait_idle();
		send_random(70);
		wait_idle();
	endtask

	// Random small frames, now and then a wider one or a size written out of
	// range; sometimes only one register is rewritten, or only the spare indexes. Item counts cover
	// partial and several whole frames.
	task automatic test_random_frames();
		int sent;
		int w;
		int h;
		int n;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			sender_gaps     = $urandom_range(0, 3) != 0;
			receiver_stalls = $urandom_range(0, 3) != 0;
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 80) : $urandom_range(5, 16);
			h = $urandom_range(5, 12);
			wait_idle();
			case ($urandom_range(0, 5))
				0: write_reg(CFG_WIDTH, CFG_DATA_W'(w));
				1: write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
				2: begin
					write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
					write_reg(CFG_WIDTH, CFG_DATA_W'(w));
				end
				3: begin
					write_reg(CFG_WIDTH, CFG_DATA_W'($urandom_range(0, MIN_SIZE - 1)));
					write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
				end
				4: begin
					write_reg(CFG_SPARE_2, CFG_DATA_W'($urandom));
					write_reg(CFG_SPARE_3, CFG_DATA_W'($urandom));
				end
				default: begin
					write_reg(CFG_WIDTH, CFG_DATA_W'(w));
					write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
				end
			endcase
			n = $urandom_range(1, 2 * width_now * height_now + 4 * width_now);
			if (n > 150)
				n = 150;
			send_random(n);
			sent += n;
		end
		wait_idle();
	endtask

	// Closing stretch at full rate on both sides.
	task automatic test_steady_stream();
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b0;
		set_size(8, 6);
		send_random(200);
		wait_idle();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		errors          = 0;
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_idx   <= CFG_WIDTH;
		cfg_data  <= '0;
		pix_valid <= 1'b0;
		pix       <= '0;

		// predictor out of reset
		for (int k = 0; k < HIST_DEPTH; k++)
			pixel_history[k] = '0;
		width_now  = WIDTH_RESET;
		height_now = HEIGHT_RESET;
		restart_stream();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_size();
		test_smallest_frame();
		test_register_limits();
		test_widest_rows();
		test_tallest_frame();
		test_pause_mid_frame();
		test_random_frames();
		test_steady_stream();

		if (pending_results.size() != 0) begin
			$display("%0t: %0d result items never arrived", $time, pending_results.size());
			errors++;
		end
		if (errors == 0)
			$display("diagonal_motion_blur_5tap_top_test passed");
		else
			$display("diagonal_motion_blur_5tap_top_test failed");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#20_000_000;
		$display("diagonal_motion_blur_5tap_top_test failed");
		$finish;
	end

endmodule

[files.f]
hdl/dmb5_pkg.sv
hdl/diagonal_motion_blur_5tap_top.sv
dv/diagonal_motion_blur_5tap_top_test.sv
